// ----- hw/rtl/oli_pkg.sv -----
// Package for the ordered list block: command and status codes, widths,
// default sizes and the control word broadcast to the storage cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oli_pkg;

    // Fixed field widths of the command and response beats
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;

    // Default sizes
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CNT_W_DEF       = $clog2(CAPACITY_DEF + 1);

    // Largest supported capacity sets the width of the cell control word
    localparam int CAPACITY_MAX = 4096;
    localparam int CTL_W        = $clog2(CAPACITY_MAX + 1);

    // Cells per first-level group of the read tree
    localparam int GRP = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND   = 3'd0,
        CMD_INSERT   = 3'd1,
        CMD_REMOVE   = 3'd2,
        CMD_SET      = 3'd3,
        CMD_GET_AT   = 3'd4,
        CMD_GET_LAST = 3'd5,
        CMD_CLEAR    = 3'd6
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Broadcast to every cell in the update cycle
    typedef struct packed {
        logic             wr;   // load new value at index pos
        logic             up;   // cells pos+1..cnt take left neighbour
        logic             dn;   // cells pos..cnt-2 take right neighbour
        logic [CTL_W-1:0] pos;
        logic [CTL_W-1:0] cnt;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/oli_if.sv -----
// Handshake interfaces for the ordered list block: command and response.
// Depends on oli_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface oli_cmd_if #(
    parameter int CNT_W = oli_pkg::CNT_W_DEF
);
    logic                      valid;
    logic                      ready;
    logic [oli_pkg::CMD_W-1:0] command;
    logic [CNT_W-1:0]          position;
    logic [oli_pkg::DATA_W-1:0] element_value;

    modport source (output valid, command, position, element_value, input ready);
    modport sink   (input valid, command, position, element_value, output ready);
endinterface

interface oli_rsp_if #(
    parameter int CNT_W = oli_pkg::CNT_W_DEF
);
    logic                       valid;
    logic                       ready;
    logic [oli_pkg::DATA_W-1:0] read_value;
    logic [CNT_W-1:0]           count;
    logic [oli_pkg::ST_W-1:0]   status;

    modport source (output valid, read_value, count, status, input ready);
    modport sink   (input valid, read_value, count, status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/oli_cell.sv -----
// One storage cell of the ordered list: holds one entry and takes a new
// value, its left or right neighbour, or holds. Depends on oli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oli_cell #(
    parameter int IDX = 0,
    parameter int W   = oli_pkg::VALUE_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire oli_pkg::t_cell_ctl i_ctl,
    input  wire [W-1:0]             i_new,
    input  wire [W-1:0]             i_left,
    input  wire [W-1:0]             i_right,
    output logic [W-1:0]            o_val
);

    localparam logic [oli_pkg::CTL_W-1:0] MY_IDX = oli_pkg::CTL_W'(IDX);
    localparam logic [oli_pkg::CTL_W-1:0] NX_IDX = oli_pkg::CTL_W'(IDX + 1);

    logic [W-1:0] r_val;
    logic [W-1:0] n_val;
    logic         w_hit_wr;
    logic         w_hit_up;
    logic         w_hit_dn;

    // Own-index decode of the broadcast control word
    assign w_hit_wr = i_ctl.wr && (i_ctl.pos == MY_IDX);
    assign w_hit_up = i_ctl.up && (MY_IDX > i_ctl.pos) && (MY_IDX <= i_ctl.cnt);
    assign w_hit_dn = i_ctl.dn && (MY_IDX >= i_ctl.pos) && (NX_IDX < i_ctl.cnt);

    always_comb begin
        n_val = r_val;
        if (w_hit_wr) begin
            n_val = i_new;
        end else if (w_hit_up) begin
            n_val = i_left;
        end else if (w_hit_dn) begin
            n_val = i_right;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

// ----- hw/rtl/oli_rd_tree.sv -----
// Registered read tree: picks one cell by index through groups of eight,
// registered once, then an OR over the groups. Depends on oli_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oli_rd_tree #(
    parameter int CAPACITY = oli_pkg::CAPACITY_DEF,
    parameter int W        = oli_pkg::VALUE_WIDTH_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire              i_clk,
    input  wire              i_cap,
    input  wire              i_hit,
    input  wire [IDX_W-1:0]  i_sel,
    input  wire [W-1:0]      i_val [CAPACITY],
    output logic [W-1:0]     o_val
);

    localparam int NGRP = (CAPACITY + oli_pkg::GRP - 1) / oli_pkg::GRP;
    localparam int NTRM = NGRP * oli_pkg::GRP;

    logic [W-1:0] w_term [NTRM];
    logic [W-1:0] n_grp  [NGRP];
    logic [W-1:0] r_grp  [NGRP];

    // Masked term per cell, zero beyond the last cell
    for (genvar i = 0; i < NTRM; i++) begin : g_term
        if (i < CAPACITY) begin : g_cell
            assign w_term[i] = (i_hit && (i_sel == IDX_W'(i))) ? i_val[i] : '0;
        end else begin : g_pad
            assign w_term[i] = '0;
        end
    end

    // First level: OR of eight terms per group, registered
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            n_grp[g] = '0;
            for (int j = 0; j < oli_pkg::GRP; j++) begin
                n_grp[g] = n_grp[g] | w_term[g * oli_pkg::GRP + j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cap) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // Second level: OR over the groups
    always_comb begin
        o_val = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_val = o_val | r_grp[g];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_insert_remove.sv -----
// Ordered list block: command decode, row of storage cells, read tree and
// response register. Depends on oli_pkg, oli_if, oli_cell and oli_rd_tree.
//
// Usage:
//   i_cmd carries one command per beat (append, insert at, remove at, set at,
//   get at, get last, clear) with a position and a value. o_rsp returns one
//   beat per command: the value read, the entry count after the command and
//   a status (ok, list full, position out of range). Failed commands leave
//   the list unchanged.
//   Each command runs through capture, cell update with the read tree's
//   first level, then the response register load. A new command is taken
//   once the last has loaded its response. The cells shift all entries in
//   the update step, so insert and remove cost the same as any other command.
//   The response register sits between the two sides: while a response
//   waits, the next command is still taken and worked on; it then holds in
//   the last step until the waiting response is taken.
//   Reset empties the list and drops any pending response. Cell contents are
//   not cleared; only entries below the count are ever read.
//
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove #(
    parameter int CAPACITY    = oli_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = oli_pkg::VALUE_WIDTH_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    oli_cmd_if.sink   i_cmd,
    oli_rsp_if.source o_rsp
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int KEEP_W = (VALUE_WIDTH < oli_pkg::DATA_W) ? VALUE_WIDTH : oli_pkg::DATA_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Captured command
    oli_pkg::t_cmd r_cmd;
    logic [CNT_W-1:0]  r_pos;
    logic [KEEP_W-1:0] r_val;

    // List state and step results
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    oli_pkg::t_status        r_st;
    oli_pkg::t_status        n_st;

    // Response register
    logic                       r_out_vld;
    logic [oli_pkg::DATA_W-1:0] r_out_rd;
    logic [CNT_W-1:0]           r_out_cnt;
    oli_pkg::t_status           r_out_st;

    oli_pkg::t_cell_ctl w_ctl;
    logic               w_full;
    logic               w_hit;
    logic [IDX_W-1:0]   w_sel;
    logic               w_acc;
    logic               w_load;
    logic [KEEP_W-1:0]  w_cell [CAPACITY];
    logic [KEEP_W-1:0]  w_rd;

    assign w_acc  = i_cmd.valid && i_cmd.ready;
    assign w_load = (r_state == S_READ) && (!r_out_vld || o_rsp.ready);
    assign w_full = (r_count == CAP_CNT);

    assign i_cmd.ready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_EXEC;
            S_EXEC: n_state = S_READ;
            S_READ: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Command decode against the current count
    always_comb begin
        w_ctl   = '0;
        n_count = r_count;
        n_st    = oli_pkg::ST_OK;
        w_hit   = 1'b0;
        w_sel   = IDX_W'(r_pos);
        w_ctl.cnt = oli_pkg::CTL_W'(r_count);
        w_ctl.pos = oli_pkg::CTL_W'(r_pos);
        unique case (r_cmd)
            oli_pkg::CMD_APPEND: begin
                if (w_full) begin
                    n_st = oli_pkg::ST_FULL;
                end else begin
                    w_ctl.wr  = 1'b1;
                    w_ctl.pos = oli_pkg::CTL_W'(r_count);
                    n_count   = r_count + 1'b1;
                end
            end
            oli_pkg::CMD_INSERT: begin
                if (r_pos > r_count) begin
                    n_st = oli_pkg::ST_RANGE;
                end else if (w_full) begin
                    n_st = oli_pkg::ST_FULL;
                end else begin
                    w_ctl.wr = 1'b1;
                    w_ctl.up = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            oli_pkg::CMD_REMOVE: begin
                if (r_pos >= r_count) begin
                    n_st = oli_pkg::ST_RANGE;
                end else begin
                    w_ctl.dn = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            oli_pkg::CMD_SET: begin
                if (r_pos >= r_count) begin
                    n_st = oli_pkg::ST_RANGE;
                end else begin
                    w_ctl.wr = 1'b1;
                end
            end
            oli_pkg::CMD_GET_AT: begin
                w_hit = (r_pos < r_count);
            end
            oli_pkg::CMD_GET_LAST: begin
                w_hit = (r_count != '0);
                w_sel = IDX_W'(r_count - 1'b1);
            end
            oli_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: ;
        endcase
        // Only the update cycle reaches the cells
        if (r_state != S_EXEC) begin
            w_ctl.wr = 1'b0;
            w_ctl.up = 1'b0;
            w_ctl.dn = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd <= oli_pkg::t_cmd'(i_cmd.command);
            r_pos <= i_cmd.position;
            r_val <= i_cmd.element_value[KEEP_W-1:0];
        end
        if (r_state == S_EXEC) begin
            r_st <= n_st;
        end
        if (w_load) begin
            r_out_rd  <= oli_pkg::DATA_W'(w_rd);
            r_out_cnt <= r_count;
            r_out_st  <= r_st;
        end
    end

    // Row of cells, each wired to its neighbours
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEEP_W-1:0] w_left;
        logic [KEEP_W-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[i+1];
        end

        oli_cell #(
            .IDX (i),
            .W   (KEEP_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_new   (r_val),
            .i_left  (w_left),
            .i_right (w_right),
            .o_val   (w_cell[i])
        );
    end

    // Read path, first level captured in the update cycle
    oli_rd_tree #(
        .CAPACITY (CAPACITY),
        .W        (KEEP_W),
        .IDX_W    (IDX_W)
    ) u_rd_tree (
        .i_clk (i_clk),
        .i_cap (r_state == S_EXEC),
        .i_hit (w_hit),
        .i_sel (w_sel),
        .i_val (w_cell),
        .o_val (w_rd)
    );

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.count      = r_out_cnt;
    assign o_rsp.status     = r_out_st;

endmodule

`default_nettype wire

// ----- hw/rtl/oli_chk.sv -----
// Port-level checker for the ordered list block, bound to the top level.
// Depends on oli_pkg and ordered_list_insert_remove.
`timescale 1ns / 1ps
`default_nettype none

module oli_chk #(
    parameter int CAPACITY = oli_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input wire                       i_clk,
    input wire                       i_rst_n,
    input wire                       i_out_valid,
    input wire                       i_out_ready,
    input wire [oli_pkg::DATA_W-1:0] i_read_value,
    input wire [CNT_W-1:0]           i_count,
    input wire [oli_pkg::ST_W-1:0]   i_status
);

    // Count never passes capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_count <= CNT_W'(CAPACITY)))
        else $error("count beyond capacity");

    // A full status only ever comes with a full list
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == oli_pkg::ST_FULL)) |-> (i_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    // A value is read only by a successful command on a non-empty list
    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_read_value != '0)) |->
            ((i_status == oli_pkg::ST_OK) && (i_count != '0)))
        else $error("read value with error status or empty list");

    // A stalled response beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_read_value) && $stable(i_count) && $stable(i_status)))
        else $error("response beat changed while stalled");

endmodule

bind ordered_list_insert_remove oli_chk #(
    .CAPACITY (CAPACITY)
) u_oli_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_read_value (o_rsp.read_value),
    .i_count      (o_rsp.count),
    .i_status     (o_rsp.status)
);

`default_nettype wire

// ----- sim/ordered_list_insert_remove_tb.sv -----
// Testbench for the ordered list block: a table of directed commands, then
// random command streams checked beat by beat against a local list model.
// Depends on oli_pkg, oli_if and the ordered_list_insert_remove RTL.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove_tb;

    localparam int CNT_W       = oli_pkg::CNT_W_DEF;
    localparam int LIST_DEPTH  = oli_pkg::CAPACITY_DEF;
    localparam int POS_MAX     = (1 << CNT_W) - 1;

    // Command code with no meaning: the list must ignore it
    localparam logic [oli_pkg::CMD_W-1:0] CMD_RESERVED = 3'd7;

    localparam int RANDOM_PER_PHASE = 90;
    localparam int FILL_APPENDS     = LIST_DEPTH + 2;
    localparam int LONG_HOLD        = 300;
    localparam int DRAIN_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int N_DIRECTED       = 25;

    typedef struct packed {
        logic [oli_pkg::DATA_W-1:0] read_value;
        logic [CNT_W-1:0]           count;
        logic [oli_pkg::ST_W-1:0]   status;
    } t_list_reply;

    typedef struct packed {
        logic [oli_pkg::CMD_W-1:0]  op;
        logic [CNT_W-1:0]           pos;
        logic [oli_pkg::DATA_W-1:0] val;
        logic                       typed;   // reply below is fixed, else use the model
        t_list_reply                reply;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    oli_cmd_if #(.CNT_W(CNT_W)) cmd_if ();
    oli_rsp_if #(.CNT_W(CNT_W)) rsp_if ();

    ordered_list_insert_remove u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Local copy of the list
    logic [oli_pkg::DATA_W-1:0] list_cells [LIST_DEPTH];
    int                         list_len = 0;

    t_list_reply replies_expected [$];

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    bit  stall_request  = 1'b0;
    int  fail_count     = 0;
    int  cmds_sent      = 0;
    int  peak_len       = 0;
    int  full_rejects   = 0;
    int  range_rejects  = 0;
    int  cycle_count    = 0;

    // Directed commands, run from reset
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{oli_pkg::CMD_GET_LAST, 7'd0, 32'h0000_0000, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_GET_AT, 7'd0, 32'h0000_0000, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_REMOVE, 7'd0, 32'h0000_0000, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_RANGE}},
        '{oli_pkg::CMD_SET, 7'd0, 32'hDEAD_BEEF, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_RANGE}},
        '{oli_pkg::CMD_INSERT, 7'd1, 32'h0000_0001, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_RANGE}},
        '{CMD_RESERVED, 7'd127, 32'hFFFF_FFFF, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_APPEND, 7'd0, 32'hFFFF_FFFF, 1'b1, '{32'd0, 7'd1, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_APPEND, 7'd127, 32'h0000_0000, 1'b1, '{32'd0, 7'd2, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_INSERT, 7'd0, 32'hA5A5_A5A5, 1'b1, '{32'd0, 7'd3, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_INSERT, 7'd3, 32'h5A5A_5A5A, 1'b1, '{32'd0, 7'd4, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_GET_AT, 7'd0, 32'h0000_0000, 1'b1,
          '{32'hA5A5_A5A5, 7'd4, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_GET_LAST, 7'd0, 32'h0000_0000, 1'b1,
          '{32'h5A5A_5A5A, 7'd4, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_INSERT, 7'd2, 32'h0000_0001, 1'b0, '0},
        '{oli_pkg::CMD_SET, 7'd4, 32'h8000_0000, 1'b0, '0},
        '{oli_pkg::CMD_GET_AT, 7'd1, 32'h0000_0000, 1'b0, '0},
        '{oli_pkg::CMD_REMOVE, 7'd0, 32'h0000_0000, 1'b0, '0},
        '{oli_pkg::CMD_GET_AT, 7'd3, 32'h0000_0000, 1'b0, '0},
        '{oli_pkg::CMD_GET_AT, 7'd127, 32'h0000_0000, 1'b1, '{32'd0, 7'd4, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_INSERT, 7'd64, 32'h0000_0001, 1'b1, '{32'd0, 7'd4, oli_pkg::ST_RANGE}},
        '{oli_pkg::CMD_REMOVE, 7'd4, 32'h0000_0000, 1'b1, '{32'd0, 7'd4, oli_pkg::ST_RANGE}},
        '{oli_pkg::CMD_SET, 7'd4, 32'h1234_5678, 1'b1, '{32'd0, 7'd4, oli_pkg::ST_RANGE}},
        '{oli_pkg::CMD_REMOVE, 7'd3, 32'h0000_0000, 1'b0, '0},
        '{oli_pkg::CMD_GET_LAST, 7'd0, 32'h0000_0000, 1'b0, '0},
        '{oli_pkg::CMD_CLEAR, 7'd0, 32'h0000_0000, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_OK}},
        '{oli_pkg::CMD_GET_LAST, 7'd0, 32'h0000_0000, 1'b1, '{32'd0, 7'd0, oli_pkg::ST_OK}}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one command to the local list and returns the reply it gives
    function automatic t_list_reply list_apply(input logic [oli_pkg::CMD_W-1:0] op,
                                               input logic [CNT_W-1:0] pos,
                                               input logic [oli_pkg::DATA_W-1:0] val);
        t_list_reply r;
        int          i;
        r.read_value = '0;
        r.status     = oli_pkg::ST_OK;
        case (op)
            oli_pkg::CMD_APPEND: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = oli_pkg::ST_FULL;
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            oli_pkg::CMD_INSERT: begin
                // position is checked before fullness
                if (pos > list_len) begin
                    r.status = oli_pkg::ST_RANGE;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = oli_pkg::ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) list_cells[i] = list_cells[i-1];
                    list_cells[pos] = val;
                    list_len++;
                end
            end
            oli_pkg::CMD_REMOVE: begin
                if (pos >= list_len) begin
                    r.status = oli_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            oli_pkg::CMD_SET: begin
                if (pos >= list_len) r.status = oli_pkg::ST_RANGE;
                else list_cells[pos] = val;
            end
            oli_pkg::CMD_GET_AT: begin
                if (pos < list_len) r.read_value = list_cells[pos];
            end
            oli_pkg::CMD_GET_LAST: begin
                if (list_len > 0) r.read_value = list_cells[list_len-1];
            end
            oli_pkg::CMD_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count = list_len[CNT_W-1:0];
        return r;
    endfunction

    // Offers one command beat, waits for it to be taken, queues its reply
    task automatic send_command(input logic [oli_pkg::CMD_W-1:0] op,
                                input logic [CNT_W-1:0] pos,
                                input logic [oli_pkg::DATA_W-1:0] val,
                                input bit typed,
                                input t_list_reply typed_reply);
        t_list_reply predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid         <= 1'b1;
        cmd_if.command       <= op;
        cmd_if.position      <= pos;
        cmd_if.element_value <= val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        predicted = list_apply(op, pos, val);
        replies_expected.push_back(typed ? typed_reply : predicted);
        cmds_sent++;
        if (list_len > peak_len) peak_len = list_len;
        if (predicted.status == oli_pkg::ST_FULL) full_rejects++;
        if (predicted.status == oli_pkg::ST_RANGE) range_rejects++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : sink_side
        int hold_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                hold_left     = LONG_HOLD;
                stall_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Reply checker: each beat against the oldest expectation
    always @(posedge i_clk) begin : check_replies
        t_list_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (replies_expected.size() == 0) begin
                $display("%0t: reply beat with none expected: %h count %0d status %0d",
                         $time, rsp_if.read_value, rsp_if.count, rsp_if.status);
                fail_count++;
            end else begin
                want = replies_expected.pop_front();
                if (rsp_if.read_value !== want.read_value) begin
                    $display("%0t: read_value expected %h got %h",
                             $time, want.read_value, rsp_if.read_value);
                    fail_count++;
                end
                if (rsp_if.count !== want.count) begin
                    $display("%0t: count expected %0d got %0d",
                             $time, want.count, rsp_if.count);
                    fail_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, rsp_if.status);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[ordered_list_insert_remove] ERROR");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        logic [oli_pkg::CMD_W-1:0]  op;
        logic [CNT_W-1:0]           pos;
        logic [oli_pkg::DATA_W-1:0] val;
        int                         r;
        bit                         growing;
        growing              = 1'b1;
        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.command       = oli_pkg::CMD_APPEND;
        cmd_if.position      = '0;
        cmd_if.element_value = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (directed_rows[k])
            send_command(directed_rows[k].op, directed_rows[k].pos, directed_rows[k].val,
                         directed_rows[k].typed, directed_rows[k].reply);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 84; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 84; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase

            // Random commands, drifting between filling and draining the list
            repeat (RANDOM_PER_PHASE) begin
                if (list_len == 0) growing = 1'b1;
                else if (list_len >= LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
                else if ($urandom_range(99) < 3) growing = !growing;

                r = $urandom_range(99);
                if (growing) begin
                    if (r < 30)      op = oli_pkg::CMD_APPEND;
                    else if (r < 55) op = oli_pkg::CMD_INSERT;
                    else if (r < 65) op = oli_pkg::CMD_REMOVE;
                    else if (r < 75) op = oli_pkg::CMD_SET;
                    else if (r < 87) op = oli_pkg::CMD_GET_AT;
                    else if (r < 96) op = oli_pkg::CMD_GET_LAST;
                    else if (r < 98) op = oli_pkg::CMD_CLEAR;
                    else             op = CMD_RESERVED;
                end else begin
                    if (r < 10)      op = oli_pkg::CMD_APPEND;
                    else if (r < 18) op = oli_pkg::CMD_INSERT;
                    else if (r < 60) op = oli_pkg::CMD_REMOVE;
                    else if (r < 70) op = oli_pkg::CMD_SET;
                    else if (r < 84) op = oli_pkg::CMD_GET_AT;
                    else if (r < 96) op = oli_pkg::CMD_GET_LAST;
                    else if (r < 98) op = oli_pkg::CMD_CLEAR;
                    else             op = CMD_RESERVED;
                end

                // mostly in range, some just past the end, some anywhere
                r = $urandom_range(9);
                if (r < 7)       pos = CNT_W'($urandom_range(list_len));
                else if (r == 7) pos = CNT_W'(list_len);
                else if (r == 8) pos = CNT_W'($urandom_range(LIST_DEPTH, list_len));
                else             pos = CNT_W'($urandom_range(POS_MAX));

                r = $urandom_range(15);
                if (r == 0)      val = '0;
                else if (r == 1) val = '1;
                else             val = $urandom;

                send_command(op, pos, val, 1'b0, '0);
            end

            // Long receiver hold-off with the sender flat out: fills the list
            // and backs the block up to its command side
            if (phase == 0) begin
                stall_request = 1'b1;
                send_command(oli_pkg::CMD_CLEAR, '0, '0, 1'b0, '0);
                repeat (FILL_APPENDS)
                    send_command(oli_pkg::CMD_APPEND, CNT_W'($urandom_range(POS_MAX)),
                                 $urandom, 1'b0, '0);
                send_command(oli_pkg::CMD_INSERT, CNT_W'($urandom_range(LIST_DEPTH)),
                             $urandom, 1'b0, '0);
                send_command(oli_pkg::CMD_INSERT, CNT_W'(LIST_DEPTH + 1), $urandom, 1'b0, '0);
                send_command(oli_pkg::CMD_GET_AT, CNT_W'(LIST_DEPTH - 1), '0, 1'b0, '0);
                send_command(oli_pkg::CMD_SET, CNT_W'(LIST_DEPTH - 1), $urandom, 1'b0, '0);
                send_command(oli_pkg::CMD_GET_LAST, '0, '0, 1'b0, '0);
                growing = 1'b0;
            end
        end

        cmd_if.valid <= 1'b0;
        while (replies_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d list commands (%0d from the table) over four idling mixes",
                 cmds_sent, N_DIRECTED);
        $display("and a long hold-off; peak length %0d, %0d full-list and %0d bad-position rejections.",
                 peak_len, full_rejects, range_rejects);
        if (fail_count == 0) begin
            $display("[ordered_list_insert_remove] OK");
        end else begin
            $display("[ordered_list_insert_remove] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
